// ----- rtl/lab_pkg.sv -----
// ----------------------------------------------------------------------------
// lab_pkg: shared types and constants for the logarithm-by-squaring unit
// Fixed-point widths, sequencer states, unit request struct, digit table.
// ----------------------------------------------------------------------------
`default_nettype none

package lab_pkg;

    localparam int unsigned IN_FRAC   = 16;            // operand / base fraction bits
    localparam int unsigned RES_FRAC  = 24;            // result fraction bits
    localparam int unsigned Z_FRAC    = 2 * IN_FRAC;   // working value fraction bits
    localparam int unsigned ZW        = 64;            // working value width
    localparam int unsigned BW        = 32;            // base width
    localparam int unsigned YW        = 34;            // accumulator width
    localparam int unsigned NUMW      = ZW + IN_FRAC;  // dividend width
    localparam int unsigned PW        = 2 * ZW;        // full product width

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_BASE    = 2'd2;
    localparam logic [1:0] ST_SAT     = 2'd3;

    // configuration register indexes
    localparam logic CFG_LOG_BASE  = 1'b0;
    localparam logic CFG_PRECISION = 1'b1;

    localparam logic [BW-1:0] BASE_RESET = 32'd178145;
    localparam logic [3:0]    PREC_RESET = 4'd8;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DCHK,
        S_DIV,
        S_MCHK,
        S_MUL,
        S_KCHK,
        S_SQR,
        S_DONE
    } t_state;

    // request to the shared arithmetic units
    typedef struct packed {
        logic div_start;
        logic mul_start;
        logic mul_square;
    } t_unit_req;

    // number of squarings for a digit count, capped at the result fraction
    function automatic logic [4:0] squarings(input logic [3:0] digits);
        logic [4:0] k;
        begin
            case (digits)
                4'd0:    k = 5'd1;
                4'd1:    k = 5'd4;
                4'd2:    k = 5'd7;
                4'd3:    k = 5'd10;
                4'd4:    k = 5'd14;
                4'd5:    k = 5'd17;
                4'd6:    k = 5'd20;
                default: k = 5'd24;
            endcase
            if (k > 5'(RES_FRAC)) k = 5'(RES_FRAC);
            return k;
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/lab_div.sv -----
// ----------------------------------------------------------------------------
// lab_div: restoring divider, one quotient bit per cycle
// Computes floor((z << 16) / base).
// ----------------------------------------------------------------------------
`default_nettype none

module lab_div (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  lab_pkg::t_unit_req      i_req,
    input  wire [lab_pkg::ZW-1:0]   i_z,
    input  wire [lab_pkg::BW-1:0]   i_base,
    output logic                    o_done,
    output logic [lab_pkg::ZW-1:0]  o_quo
);
    import lab_pkg::*;

    logic [NUMW-1:0] r_num;
    logic [BW:0]     r_rem;
    logic [ZW-1:0]   r_quo;
    logic [BW-1:0]   r_base;
    logic [6:0]      r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [BW:0]     shifted;
    logic [BW:0]     trial;
    logic            qbit;

    // trial subtract for this bit
    always_comb begin
        shifted = {r_rem[BW-1:0], r_num[NUMW-1]};
        trial   = shifted - {1'b0, r_base};
        qbit    = (shifted >= {1'b0, r_base});
    end

    // control: start, count bits, flag completion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.div_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'(NUMW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: shift in dividend bits, build quotient
    always_ff @(posedge i_clk) begin
        if (i_req.div_start) begin
            r_num  <= {i_z, {IN_FRAC{1'b0}}};
            r_rem  <= '0;
            r_quo  <= '0;
            r_base <= i_base;
        end else if (r_busy) begin
            r_num <= {r_num[NUMW-2:0], 1'b0};
            r_rem <= qbit ? trial : shifted;
            r_quo <= {r_quo[ZW-2:0], qbit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

// ----- rtl/lab_mul.sv -----
// ----------------------------------------------------------------------------
// lab_mul: 64 x 64 multiplier from one shared 32 x 32 multiplier
// Four partial products, registered, accumulated into a 128-bit sum.
// ----------------------------------------------------------------------------
`default_nettype none

module lab_mul (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  lab_pkg::t_unit_req      i_req,
    input  wire [lab_pkg::ZW-1:0]   i_z,
    input  wire [lab_pkg::BW-1:0]   i_base,
    output logic                    o_done,
    output logic [lab_pkg::PW-1:0]  o_prod
);
    import lab_pkg::*;

    logic [ZW-1:0] r_a;
    logic [ZW-1:0] r_b;
    logic [ZW-1:0] r_pp;
    logic [1:0]    r_pp_sh;
    logic [PW-1:0] r_acc;
    logic [2:0]    r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [31:0]   op_a;
    logic [31:0]   op_b;
    logic [PW-1:0] pp_aligned;

    // pick the halves for this partial product and align the previous one
    always_comb begin
        op_a = r_cnt[0] ? r_a[ZW-1:32] : r_a[31:0];
        op_b = r_cnt[1] ? r_b[ZW-1:32] : r_b[31:0];
        case (r_pp_sh)
            2'd0:    pp_aligned = {64'd0, r_pp};
            2'd1:    pp_aligned = {32'd0, r_pp, 32'd0};
            default: pp_aligned = {r_pp, 64'd0};
        endcase
    end

    // control: step through partial products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.mul_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: multiply, then accumulate on the following cycle
    always_ff @(posedge i_clk) begin
        if (i_req.mul_start) begin
            r_a   <= i_z;
            r_b   <= i_req.mul_square ? i_z : {32'd0, i_base};
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_cnt != 3'd4) begin
                r_pp    <= op_a * op_b;
                r_pp_sh <= 2'(r_cnt[0]) + 2'(r_cnt[1]);
            end
            if (r_cnt != 3'd0) r_acc <= r_acc + pp_aligned;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

// ----- rtl/log_any_base_by_squaring_unit.sv -----
// Sequence: a zero operand or bad base goes straight to the result; otherwise
//   divisions by the base, multiplications by the base and squarings
//   (up to 24 squarings), all on shared iterative units.
// Throughput: one item at a time; the next item is taken once the result is
//   registered for output. Divider bit loop dominates large operands.
// Reset: synchronous, active low; config registers return to base e and 8 digits.
// ----------------------------------------------------------------------------
// log_any_base_by_squaring_unit: logarithm to a configurable base
// Digit-by-digit squaring method on a Q32.32 working value, Q8.24 result.
// ----------------------------------------------------------------------------
`default_nettype none

module log_any_base_by_squaring_unit (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_stall,
    input  wire [31:0]              i_operand,
    output logic                    o_out_valid,
    input  wire                     i_out_stall,
    output logic signed [31:0]      o_log_value,
    output logic [1:0]              o_status,
    input  wire                     i_cfg_wr_en,
    input  wire                     i_cfg_index,
    input  wire [31:0]              i_cfg_wr_data
);
    import lab_pkg::*;

    localparam logic [ZW-1:0]     ONE   = ZW'(1) << Z_FRAC;
    localparam logic signed [YW-1:0] Y_MAX = YW'(32'sh7FFF_FFFF);
    localparam logic signed [YW-1:0] Y_MIN = -(YW'(1) << 31);

    t_state          r_state, n_state;
    logic [BW-1:0]   r_log_base;
    logic [3:0]      r_prec;
    logic [ZW-1:0]   r_z, n_z;
    logic signed [YW-1:0] r_y, n_y;
    logic [4:0]      r_k, n_k;
    logic [4:0]      r_kmax, n_kmax;
    logic [1:0]      r_st, n_st;
    logic            r_out_valid;
    logic signed [31:0] r_out_log;
    logic [1:0]      r_out_st;
    t_unit_req       req;
    logic            div_done, mul_done;
    logic [ZW-1:0]   quo;
    logic [PW-1:0]   prod;
    logic            in_acc, out_free;
    logic signed [YW-1:0] w, y_up, y_dn;
    logic [ZW-1:0]   limit, nz_mul;

    lab_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req), .i_z(r_z),
        .i_base(r_log_base), .o_done(div_done), .o_quo(quo)
    );

    lab_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req), .i_z(r_z),
        .i_base(r_log_base), .o_done(mul_done), .o_prod(prod)
    );

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log_base <= BASE_RESET;
            r_prec     <= PREC_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_LOG_BASE:  r_log_base <= i_cfg_wr_data;
                CFG_PRECISION: r_prec     <= i_cfg_wr_data[3:0];
                default:       r_prec     <= r_prec;
            endcase
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_z    <= n_z;
        r_y    <= n_y;
        r_k    <= n_k;
        r_kmax <= n_kmax;
        r_st   <= n_st;
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_log <= r_y[31:0];
            r_out_st  <= r_st;
        end
    end

    // digit weight and candidate sums
    always_comb begin
        w      = YW'(1) << (5'(RES_FRAC) - r_k);
        y_up   = r_y + w;
        y_dn   = r_y - w;
        limit  = {{(ZW-BW-IN_FRAC){1'b0}}, r_log_base, {IN_FRAC{1'b0}}};
        nz_mul = prod[ZW+IN_FRAC-1:IN_FRAC];
    end

    // next state and unit requests
    always_comb begin
        n_state = r_state;
        n_z     = r_z;
        n_y     = r_y;
        n_k     = r_k;
        n_kmax  = r_kmax;
        n_st    = r_st;
        req     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_y    = '0;
                    n_k    = '0;
                    n_z    = {{(ZW-32-IN_FRAC){1'b0}}, i_operand, {IN_FRAC{1'b0}}};
                    n_kmax = squarings((r_prec > 4'd9) ? 4'd9 : r_prec);
                    if (i_operand == 32'd0) begin
                        n_st    = ST_ZERO;
                        n_state = S_DONE;
                    end else if (r_log_base <= (BW'(1) << IN_FRAC)) begin
                        n_st    = ST_BASE;
                        n_state = S_DONE;
                    end else begin
                        n_st    = ST_OK;
                        n_state = S_DCHK;
                    end
                end
            end
            S_DCHK: begin
                if (r_z >= limit) begin
                    req.div_start = 1'b1;
                    n_state       = S_DIV;
                end else begin
                    n_state = S_MCHK;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_z = quo;
                    if (y_up > Y_MAX) begin
                        n_y     = Y_MAX;
                        n_st    = ST_SAT;
                        n_state = S_DONE;
                    end else begin
                        n_y     = y_up;
                        n_state = S_DCHK;
                    end
                end
            end
            S_MCHK: begin
                if (r_z <= ONE) begin
                    req.mul_start = 1'b1;
                    n_state       = S_MUL;
                end else begin
                    n_state = S_KCHK;
                end
            end
            S_MUL: begin
                if (mul_done) begin
                    if (nz_mul > ONE) begin
                        n_state = S_KCHK;
                    end else if (nz_mul == r_z || y_dn < Y_MIN) begin
                        n_y     = Y_MIN;
                        n_st    = ST_SAT;
                        n_state = S_DONE;
                    end else begin
                        n_y     = y_dn;
                        n_z     = nz_mul;
                        n_state = S_MCHK;
                    end
                end
            end
            S_KCHK: begin
                if (r_k >= r_kmax) begin
                    n_state = S_DONE;
                end else begin
                    req.mul_start  = 1'b1;
                    req.mul_square = 1'b1;
                    n_state        = S_SQR;
                end
            end
            S_SQR: begin
                if (mul_done) begin
                    n_z     = prod[ZW+Z_FRAC-1:Z_FRAC];
                    n_k     = r_k + 5'd1;
                    n_state = S_DCHK;
                end
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_log_value = r_out_log;
    assign o_status    = r_out_st;

endmodule

`default_nettype wire

// ----- rtl/lab_chk.sv -----
// ----------------------------------------------------------------------------
// lab_chk: port-level checker for the logarithm unit
// Watches handshakes and result encoding; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lab_chk (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    input  wire        o_in_stall,
    input  wire        o_out_valid,
    input  wire        i_out_stall,
    input  wire [31:0] o_log_value,
    input  wire [1:0]  o_status,
    input  wire        i_cfg_wr_en
);
    import lab_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_log_value)
            && $stable(o_status))
        else $error("result beat dropped or changed under stall");

    // error results carry a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_ZERO || o_status == ST_BASE)
            |-> o_log_value == 32'd0)
        else $error("error status with non-zero value");

    // saturation gives one of the two range ends
    a_sat_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_SAT
            |-> (o_log_value == 32'h7FFF_FFFF || o_log_value == 32'h8000_0000))
        else $error("saturated value not at range end");

    // an accepted operand makes the unit busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("unit took an operand but did not go busy");

    // register writes must land only while the unit is idle; the unit does not enforce it
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |-> !o_in_stall)
        else $error("register written while the unit was busy");

endmodule

bind log_any_base_by_squaring_unit lab_chk u_lab_chk (.*);

`default_nettype wire
